FILE: sv/dstwr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_pkg: shared types and codes
// Word formats, event and send codes, configuration indexes for the
// two-way ranging responder sequencer.
// ----------------------------------------------------------------------------
package dstwr_pkg;

  localparam logic [1:0] EV_TICK   = 2'd0;
  localparam logic [1:0] EV_FRAME  = 2'd1;
  localparam logic [1:0] EV_RXERR  = 2'd2;
  localparam logic [1:0] EV_TXDONE = 2'd3;

  localparam logic [1:0] SEND_NONE     = 2'd0;
  localparam logic [1:0] SEND_RESPONSE = 2'd1;
  localparam logic [1:0] SEND_ERROR    = 2'd2;
  localparam logic [1:0] SEND_TIMING   = 2'd3;

  localparam logic [1:0] CFG_ANCHOR_ID   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

  localparam logic [2:0] FSTAGE_REQUEST = 3'd1;
  localparam logic [2:0] FSTAGE_FINAL   = 3'd3;

  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned LowTsBits   = 32;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  dest_id;
    logic [2:0]  frame_stage;
    logic        is_error_frame;
    logic [39:0] event_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         send_kind;
    logic               rearm_rx;
    logic               clear_status;
    logic               reset_radio;
    logic               timed_out;
    logic signed [31:0] round_time;
    logic signed [31:0] reply_time;
    logic [1:0]         stage_now;
  } out_word_t;

  // classified event handed from front end to back end
  typedef struct packed {
    logic [1:0]           kind;
    logic                 for_me;
    logic                 is_request;
    logic                 is_final;
    logic                 err_frame;
    logic [LowTsBits-1:0] ts;
  } cmd_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [3:0]  retry_limit;
  } tmo_cfg_t;

endpackage
`default_nettype wire

FILE: sv/dstwr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_front: event classifier
// Decodes an incoming event word against the anchor id and keeps only the
// low timestamp bits that the differences need.
// ----------------------------------------------------------------------------
module dstwr_front
  import dstwr_pkg::*;
(
  input  wire in_word_t   word_i,
  input  wire logic [7:0] anchor_id_i,
  output cmd_t            cmd_o
);

  always_comb begin
    cmd_o.kind       = word_i.req_type;
    cmd_o.for_me     = (word_i.dest_id == anchor_id_i);
    cmd_o.is_request = (word_i.frame_stage == FSTAGE_REQUEST);
    cmd_o.is_final   = (word_i.frame_stage == FSTAGE_FINAL);
    cmd_o.err_frame  = word_i.is_error_frame;
    cmd_o.ts         = word_i.event_time[LowTsBits-1:0];
  end

endmodule
`default_nettype wire

FILE: sv/dstwr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_queue: two-word command queue
// Decouples the classifier from the sequencer; push and pop may happen in
// the same cycle.
// ----------------------------------------------------------------------------
module dstwr_queue
  import dstwr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      head_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/dstwr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_back: ranging sequencer
// Applies one queued event per cycle, unless a stalled result word holds it,
// to the stage, timeout and timestamp state and registers the result word.
// ----------------------------------------------------------------------------
module dstwr_back
  import dstwr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tmo_cfg_t cfg_i,
  input  wire logic     q_valid_i,
  input  wire cmd_t     q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_word_t     out_word_o
);

  localparam logic [1:0] ST_WAIT_REQ   = 2'd0;
  localparam logic [1:0] ST_SENT_RESP  = 2'd1;
  localparam logic [1:0] ST_WAIT_FINAL = 2'd2;

  logic [1:0]           stage_q, stage_d;
  logic [15:0]          elapsed_q, elapsed_d;
  logic [3:0]           retry_q, retry_d;
  logic [LowTsBits-1:0] rx_time_q, rx_time_d;
  logic [LowTsBits-1:0] tx_time_q, tx_time_d;
  logic [LowTsBits-1:0] reply_int_q, reply_int_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  logic       restart;
  logic [1:0] st;
  logic [15:0] elapsed_tick;
  logic       expired;
  logic [4:0] retry_inc;
  logic       is_tick, is_frame, is_rxerr, is_txdone;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    is_tick   = (q_head_i.kind == EV_TICK);
    is_frame  = (q_head_i.kind == EV_FRAME);
    is_rxerr  = (q_head_i.kind == EV_RXERR);
    is_txdone = (q_head_i.kind == EV_TXDONE);

    restart = is_frame && q_head_i.is_request && q_head_i.for_me &&
              (stage_q != ST_WAIT_REQ);
    st = restart ? ST_WAIT_REQ : stage_q;

    elapsed_tick = elapsed_q;
    if (is_tick && (elapsed_q != 16'hFFFF)) begin
      elapsed_tick = elapsed_q + 16'd1;
    end
    expired   = is_tick && (elapsed_tick > cfg_i.timeout_ms);
    retry_inc = {1'b0, retry_q} + 5'd1;

    stage_d     = st;
    elapsed_d   = elapsed_tick;
    retry_d     = retry_q;
    rx_time_d   = rx_time_q;
    tx_time_d   = tx_time_q;
    reply_int_d = reply_int_q;

    out_d              = '0;
    out_d.send_kind    = SEND_NONE;

    unique case (st)
      ST_WAIT_REQ: begin
        if (is_frame) begin
          out_d.clear_status = 1'b1;
          if (!q_head_i.for_me || q_head_i.err_frame) begin
            out_d.rearm_rx = 1'b1;
          end else if (!q_head_i.is_request) begin
            out_d.send_kind = SEND_ERROR;
            out_d.rearm_rx  = 1'b1;
          end else begin
            rx_time_d       = q_head_i.ts;
            reply_int_d     = '0;
            out_d.send_kind = SEND_RESPONSE;
            stage_d         = ST_SENT_RESP;
          end
        end else if (is_rxerr) begin
          out_d.clear_status = 1'b1;
        end else if (expired) begin
          out_d.timed_out = 1'b1;
          out_d.rearm_rx  = 1'b1;
          elapsed_d       = '0;
          retry_d         = retry_inc[3:0];
          if (retry_inc > {1'b0, cfg_i.retry_limit}) begin
            out_d.reset_radio = 1'b1;
            retry_d           = '0;
          end
        end
      end
      ST_SENT_RESP: begin
        if (is_txdone) begin
          tx_time_d   = q_head_i.ts;
          reply_int_d = q_head_i.ts - rx_time_q;
          elapsed_d   = '0;
          stage_d     = ST_WAIT_FINAL;
        end else if (is_frame || is_rxerr) begin
          out_d.clear_status = 1'b1;
        end
      end
      ST_WAIT_FINAL: begin
        if (is_frame) begin
          retry_d            = '0;
          out_d.clear_status = 1'b1;
          out_d.rearm_rx     = 1'b1;
          stage_d            = ST_WAIT_REQ;
          if (q_head_i.err_frame) begin
            out_d.send_kind = SEND_NONE;
          end else if (!q_head_i.is_final) begin
            out_d.send_kind = SEND_ERROR;
          end else begin
            out_d.send_kind  = SEND_TIMING;
            out_d.round_time = q_head_i.ts - tx_time_q;
            out_d.reply_time = reply_int_q;
          end
        end else if (is_rxerr) begin
          retry_d            = '0;
          out_d.clear_status = 1'b1;
        end else if (expired) begin
          out_d.timed_out = 1'b1;
          out_d.rearm_rx  = 1'b1;
          elapsed_d       = '0;
          stage_d         = ST_WAIT_REQ;
          retry_d         = retry_inc[3:0];
          if (retry_inc > {1'b0, cfg_i.retry_limit}) begin
            out_d.reset_radio = 1'b1;
            retry_d           = '0;
          end
        end
      end
      default: begin
        stage_d        = ST_WAIT_REQ;
        out_d.rearm_rx = 1'b1;
      end
    endcase

    out_d.stage_now = stage_d;
    out_valid_d     = q_pop_o || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_WAIT_REQ;
      elapsed_q   <= '0;
      retry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        stage_q   <= stage_d;
        elapsed_q <= elapsed_d;
        retry_q   <= retry_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rx_time_q   <= rx_time_d;
      tx_time_q   <= tx_time_d;
      reply_int_q <= reply_int_d;
      out_q       <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  a_timing_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.send_kind == SEND_TIMING) |->
      (out_q.stage_now == ST_WAIT_REQ && out_q.rearm_rx))
    else $error("timing send without return to request wait");

  a_reset_on_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.reset_radio) |-> out_q.timed_out)
    else $error("radio reset without timeout");

  a_result_tracks_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (out_q.stage_now == stage_q && stage_q != 2'd3))
    else $error("result stage differs from sequencer stage");
`endif

endmodule
`default_nettype wire

FILE: sv/ds_twr_responder_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ds_twr_responder_sequencer: two-way ranging responder
// Event words are classified, queued and applied to the ranging sequence.
// ----------------------------------------------------------------------------
// An accepted input word is written into the queue, then the sequencer registers its result.
// Throughput: one word per cycle while the queue has room; a stalled result holds the sequencer.
// A two-word queue absorbs up to two input words while a result is stalled.
// Reset (async, active low) clears the stage, counters and queue and loads
// the configuration defaults: anchor id 1, timeout 20 ms, 3 retries.
module ds_twr_responder_sequencer
  import dstwr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_word_t              in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_word_t                  out_word_o
);

  logic [7:0] anchor_id_q;
  tmo_cfg_t   tmo_cfg_q;
  cmd_t       front_cmd;
  cmd_t       q_head;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_id_q           <= 8'd1;
      tmo_cfg_q.timeout_ms  <= 16'd20;
      tmo_cfg_q.retry_limit <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANCHOR_ID:   anchor_id_q           <= cfg_wdata_i[7:0];
        CFG_TIMEOUT_MS:  tmo_cfg_q.timeout_ms  <= cfg_wdata_i;
        CFG_RETRY_LIMIT: tmo_cfg_q.retry_limit <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  dstwr_front u_front (
    .word_i      (in_word_i),
    .anchor_id_i (anchor_id_q),
    .cmd_o       (front_cmd)
  );

  dstwr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  dstwr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (tmo_cfg_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire
